[sv/pidaw_pkg.sv]
// pidaw_pkg: shared types, constants and saturation helpers for the
// fixed-point pid controller with anti-windup; no dependencies
`timescale 1ns / 1ps

package pidaw_pkg;

  localparam int VAL_W     = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int TAU_W     = 16;
  localparam int DIV_STEPS = VAL_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

  // reset values of the configuration registers
  localparam logic signed [VAL_W-1:0] RST_LOOP_GAIN  = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] RST_INT_GAIN   = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] RST_DER_GAIN   = '0;
  localparam logic [TAU_W-1:0]        RST_TIME_CONST = 16'd1000;
  localparam logic signed [VAL_W-1:0] RST_UPPER      = VMAX;
  localparam logic signed [VAL_W-1:0] RST_LOWER      = VMIN;

  localparam logic signed [VAL_W:0]   MUL_TWO  = 33'sd2;
  localparam logic [TAU_W-1:0]        TAU_ONE  = 16'd1;

  typedef enum logic [2:0] {
    CFG_LOOP_GAIN  = 3'd0,
    CFG_INT_GAIN   = 3'd1,
    CFG_DER_GAIN   = 3'd2,
    CFG_TIME_CONST = 3'd3,
    CFG_UPPER      = 3'd4,
    CFG_LOWER      = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_UPPER = 2'd1,
    CLAMP_LOWER = 2'd2
  } clamp_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_P,
    ST_I1,
    ST_I2,
    ST_I3,
    ST_IDIV,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_DDIV,
    ST_SUM,
    ST_CLAMP,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_ADIV,
    ST_DONE
  } state_e;

  // request to the shared multiplier: operands are 33 bit so that both
  // signed values and unsigned intervals fit
  typedef struct packed {
    logic                    go;
    logic                    shift;
    logic signed [VAL_W:0]   a;
    logic signed [VAL_W:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                    go;
    logic signed [VAL_W-1:0] num;
    logic [VAL_W-1:0]        den;
  } div_req_t;

  function automatic logic signed [VAL_W-1:0] sat34(logic signed [VAL_W+1:0] x);
    logic signed [VAL_W+1:0] hi;
    logic signed [VAL_W+1:0] lo;
    hi = {{2{VMAX[VAL_W-1]}}, VMAX};
    lo = {{2{VMIN[VAL_W-1]}}, VMIN};
    if (x > hi) begin
      return VMAX;
    end else if (x < lo) begin
      return VMIN;
    end
    return x[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W+1:0] ext34(logic signed [VAL_W-1:0] x);
    return {{2{x[VAL_W-1]}}, x};
  endfunction

  function automatic logic signed [VAL_W:0] ext33(logic signed [VAL_W-1:0] x);
    return {x[VAL_W-1], x};
  endfunction

endpackage

[sv/pid_controller_antiwindup.sv]
// pid_controller_antiwindup: top level, configuration registers, sequencer
// and datapath registers; uses pidaw_pkg, pidaw_mul and pidaw_div
`timescale 1ns / 1ps

// Fixed-point Q16.16 pid controller with anti-windup. Each item carries a
// setpoint, a measurement and a millisecond time stamp and yields one result
// item: the clamped drive, the clamp status and a flag for a zero interval.
// All arithmetic runs through one two-stage multiplier and one divider that
// retires two quotient bits per cycle, stepped by a sequencer; the block
// takes one item at a time. With a zero interval the derivative path is
// skipped, and without a clamp the anti-windup correction is skipped, so
// an item runs between one and three divides. A finished result sits
// in an output register, so the next item is accepted while it waits.
// Configuration must be written through cfg_we_i only while the block is
// idle; the block itself does not enforce this.
module pid_controller_antiwindup import pidaw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_idx_i,
  input  logic [VAL_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [VAL_W-1:0] setpoint_i,
  input  logic signed [VAL_W-1:0] measurement_i,
  input  logic [VAL_W-1:0]        now_ms_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] drive_o,
  output logic [1:0]              clamp_status_o,
  output logic                    zero_interval_o
);

  state_e state_q, state_d;

  logic signed [VAL_W-1:0] kc_q, ki_q, kd_q, ul_q, ll_q;
  logic [TAU_W-1:0]        tau_q;
  logic [TAU_W-1:0]        tau_eff;

  logic signed [VAL_W-1:0] integ_q, last_meas_q;
  logic [VAL_W-1:0]        last_time_q;

  logic signed [VAL_W-1:0] meas_q, err_q, dmeas_q, p_q, d_q, t_q, o_q;
  logic [VAL_W-1:0]        now_q, dt_q;
  clamp_e                  status_q;
  logic                    zero_q;

  logic                    out_valid_q;
  logic signed [VAL_W-1:0] drive_q;
  clamp_e                  out_status_q;
  logic                    out_zero_q;

  logic                    pend_q, pend_d;
  logic                    in_acc, out_free, is_op, is_div, issue, op_done;

  mul_req_t                mul_req;
  logic                    mul_done;
  logic signed [VAL_W-1:0] mul_res;
  div_req_t                div_req;
  logic                    div_done;
  logic signed [VAL_W:0]   div_quot;

  pidaw_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  pidaw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign tau_eff  = (tau_q == '0) ? TAU_ONE : tau_q;
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign op_done  = mul_done || div_done;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kc_q  <= RST_LOOP_GAIN;
      ki_q  <= RST_INT_GAIN;
      kd_q  <= RST_DER_GAIN;
      tau_q <= RST_TIME_CONST;
      ul_q  <= RST_UPPER;
      ll_q  <= RST_LOWER;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOOP_GAIN:  kc_q  <= cfg_data_i;
        CFG_INT_GAIN:   ki_q  <= cfg_data_i;
        CFG_DER_GAIN:   kd_q  <= cfg_data_i;
        CFG_TIME_CONST: tau_q <= cfg_data_i[TAU_W-1:0];
        CFG_UPPER:      ul_q  <= cfg_data_i;
        CFG_LOWER:      ll_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  // sequencer: each arithmetic state issues once and waits for its unit
  always_comb begin
    state_d     = state_q;
    is_op       = state_q inside {ST_P, ST_I1, ST_I2, ST_I3, ST_IDIV, ST_D1, ST_D2,
                                  ST_D3, ST_DDIV, ST_A1, ST_A2, ST_A3, ST_ADIV};
    is_div      = state_q inside {ST_IDIV, ST_DDIV, ST_ADIV};
    issue       = is_op && !pend_q;
    pend_d      = issue ? 1'b1 : (op_done ? 1'b0 : pend_q);
    in_stall_o  = (state_q != ST_IDLE);

    mul_req       = '0;
    mul_req.go    = issue && !is_div;
    div_req       = '0;
    div_req.go    = issue && is_div;
    div_req.num   = t_q;
    div_req.den   = (state_q == ST_DDIV) ? dt_q : {{(VAL_W-TAU_W){1'b0}}, tau_eff};

    case (state_q)
      ST_P: begin
        mul_req.a = ext33(kc_q); mul_req.b = ext33(err_q); mul_req.shift = 1'b1;
      end
      ST_I1: begin
        mul_req.a = ext33(ki_q); mul_req.b = ext33(err_q); mul_req.shift = 1'b1;
      end
      ST_I2, ST_A2: begin
        mul_req.a = ext33(t_q); mul_req.b = {1'b0, dt_q}; mul_req.shift = 1'b0;
      end
      ST_I3, ST_A3: begin
        mul_req.a = ext33(t_q); mul_req.b = ext33(kc_q); mul_req.shift = 1'b1;
      end
      ST_D1: begin
        mul_req.a = ext33(kd_q); mul_req.b = ext33(kc_q); mul_req.shift = 1'b1;
      end
      ST_D2: begin
        mul_req.a     = ext33(t_q);
        mul_req.b     = {{(VAL_W+1-TAU_W){1'b0}}, tau_eff};
        mul_req.shift = 1'b0;
      end
      ST_D3: begin
        mul_req.a = ext33(t_q); mul_req.b = ext33(dmeas_q); mul_req.shift = 1'b1;
      end
      ST_A1: begin
        mul_req.a = ext33(err_q); mul_req.b = MUL_TWO; mul_req.shift = 1'b0;
      end
      default: ;
    endcase

    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_P;
      ST_P:     if (op_done) state_d = ST_I1;
      ST_I1:    if (op_done) state_d = ST_I2;
      ST_I2:    if (op_done) state_d = ST_I3;
      ST_I3:    if (op_done) state_d = ST_IDIV;
      ST_IDIV:  if (op_done) state_d = (dt_q == '0) ? ST_SUM : ST_D1;
      ST_D1:    if (op_done) state_d = ST_D2;
      ST_D2:    if (op_done) state_d = ST_D3;
      ST_D3:    if (op_done) state_d = ST_DDIV;
      ST_DDIV:  if (op_done) state_d = ST_SUM;
      ST_SUM:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = (o_q > ul_q || o_q < ll_q) ? ST_A1 : ST_DONE;
      ST_A1:    if (op_done) state_d = ST_A2;
      ST_A2:    if (op_done) state_d = ST_A3;
      ST_A3:    if (op_done) state_d = ST_ADIV;
      ST_ADIV:  if (op_done) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // controller state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      last_meas_q <= '0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_done && state_q == ST_IDIV) begin
        integ_q <= sat34(ext34(integ_q) + {div_quot[VAL_W], div_quot});
      end
      if (op_done && state_q == ST_ADIV) begin
        integ_q <= sat34(ext34(integ_q) - {div_quot[VAL_W], div_quot});
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        last_meas_q <= meas_q;
        last_time_q <= now_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      meas_q  <= measurement_i;
      now_q   <= now_ms_i;
      dt_q    <= now_ms_i - last_time_q;
      err_q   <= sat34(ext34(setpoint_i) - ext34(measurement_i));
      dmeas_q <= sat34(ext34(measurement_i) - ext34(last_meas_q));
    end
    if (op_done) begin
      case (state_q)
        ST_P: p_q <= mul_res;
        ST_IDIV: begin
          d_q    <= '0;
          zero_q <= (dt_q == '0);
        end
        ST_DDIV: d_q <= sat34(-{div_quot[VAL_W], div_quot});
        default: t_q <= mul_res;
      endcase
    end
    case (state_q)
      ST_SUM: begin
        o_q      <= sat34(ext34(p_q) + ext34(integ_q) + ext34(d_q));
        status_q <= CLAMP_NONE;
      end
      ST_CLAMP: begin
        // the upper test wins when the limits cross
        if (o_q > ul_q) begin
          o_q      <= ul_q;
          status_q <= CLAMP_UPPER;
        end else if (o_q < ll_q) begin
          o_q      <= ll_q;
          status_q <= CLAMP_LOWER;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          drive_q      <= o_q;
          out_status_q <= status_q;
          out_zero_q   <= zero_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign drive_o         = drive_q;
  assign clamp_status_o  = out_status_q;
  assign zero_interval_o = out_zero_q;

endmodule

[sv/pidaw_mul.sv]
// pidaw_mul: two-stage sign-magnitude multiplier with optional fraction
// shift, truncation toward zero and saturation; uses pidaw_pkg
`timescale 1ns / 1ps

module pidaw_mul import pidaw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mul_req_t                req_i,
  output logic                    done_o,
  output logic signed [VAL_W-1:0] res_o
);

  logic signed [VAL_W:0]   a_mag;
  logic signed [VAL_W:0]   b_mag;
  logic [PROD_W-1:0]       prod_q;
  logic                    neg_q;
  logic                    shift_q;
  logic                    v1_q;
  logic                    v2_q;
  logic signed [VAL_W-1:0] res_q;
  logic [PROD_W-1:0]       m;
  logic [PROD_W-1:0]       lim;
  logic [PROD_W-1:0]       m_sat;

  assign a_mag = req_i.a[VAL_W] ? -req_i.a : req_i.a;
  assign b_mag = req_i.b[VAL_W] ? -req_i.b : req_i.b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.go;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      prod_q  <= a_mag[VAL_W-1:0] * b_mag[VAL_W-1:0];
      neg_q   <= req_i.a[VAL_W] ^ req_i.b[VAL_W];
      shift_q <= req_i.shift;
    end
    if (v1_q) begin
      res_q <= neg_q ? -m_sat[VAL_W-1:0] : m_sat[VAL_W-1:0];
    end
  end

  // magnitude limit is 2^(w-1) for a negative result, 2^(w-1)-1 otherwise
  always_comb begin
    m     = shift_q ? (prod_q >> FRAC_BITS) : prod_q;
    lim   = {{(PROD_W-VAL_W){1'b0}}, neg_q, {(VAL_W-1){~neg_q}}};
    m_sat = (m > lim) ? lim : m;
  end

  assign done_o = v2_q;
  assign res_o  = res_q;

endmodule

[sv/pidaw_div.sv]
// pidaw_div: iterative restoring divider, two quotient bits per cycle,
// signed dividend by positive divisor, truncated toward zero; uses pidaw_pkg
`timescale 1ns / 1ps

module pidaw_div import pidaw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_req_t              req_i,
  output logic                  done_o,
  output logic signed [VAL_W:0] quot_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [VAL_W-1:0]     rem_q;
  logic [VAL_W-1:0]     num_q;
  logic [VAL_W-1:0]     den_q;
  logic                 neg_q;
  logic [VAL_W:0]       r1;
  logic [VAL_W:0]       r1b;
  logic [VAL_W:0]       r2;
  logic [VAL_W:0]       r2b;
  logic                 ge1;
  logic                 ge2;
  logic signed [VAL_W-1:0] num_mag;

  assign num_mag = req_i.num[VAL_W-1] ? -req_i.num : req_i.num;

  always_comb begin
    r1  = {rem_q, num_q[VAL_W-1]};
    ge1 = r1 >= {1'b0, den_q};
    r1b = ge1 ? r1 - {1'b0, den_q} : r1;
    r2  = {r1b[VAL_W-1:0], num_q[VAL_W-2]};
    ge2 = r2 >= {1'b0, den_q};
    r2b = ge2 ? r2 - {1'b0, den_q} : r2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in at the bottom of the dividend register
  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      rem_q <= '0;
      num_q <= num_mag;
      den_q <= req_i.den;
      neg_q <= req_i.num[VAL_W-1];
    end else if (busy_q) begin
      rem_q <= r2b[VAL_W-1:0];
      num_q <= {num_q[VAL_W-3:0], ge1, ge2};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule

[dv/pid_controller_antiwindup_tb.sv]
// pid_controller_antiwindup_tb: self-checking testbench for the fixed-point
// pid controller; drives directed and random samples through valid/stall
// channels and checks each drive item against a behavioral predictor
`timescale 1ns / 1ps

module pid_controller_antiwindup_tb;
  import pidaw_pkg::*;

  localparam int IDLE_LIMIT      = 4000;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 100;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int REPORT_MAX      = 10;

  typedef struct {
    logic signed [VAL_W-1:0] drive;
    clamp_e                  status;
    logic                    zero;
  } drive_item_t;

  // tracks controller state and configuration, predicts the drive item
  class drive_scoreboard;
    longint           kc, ki, kd, hi_lim, lo_lim;
    logic [TAU_W-1:0] tau_ms;
    longint           integ, prev_meas;
    logic [VAL_W-1:0] prev_ms;
    drive_item_t      drive_due[$];
    int               failures;

    function new();
      kc        = RST_LOOP_GAIN;
      ki        = RST_INT_GAIN;
      kd        = RST_DER_GAIN;
      tau_ms    = RST_TIME_CONST;
      hi_lim    = RST_UPPER;
      lo_lim    = RST_LOWER;
      integ     = 0;
      prev_meas = 0;
      prev_ms   = '0;
      failures  = 0;
    endfunction

    function longint clip(longint x);
      if (x > longint'(VMAX)) begin
        return longint'(VMAX);
      end else if (x < longint'(VMIN)) begin
        return longint'(VMIN);
      end
      return x;
    endfunction

    // (a*b) >> sh on magnitudes, truncated toward zero, saturated
    function longint scaled_mul(longint a, longint b, int sh);
      bit         neg;
      bit [127:0] ua, ub, m, lim;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? -a : a;
      ub  = (b < 0) ? -b : b;
      m   = (ua * ub) >> sh;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (m > lim) m = lim;
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function void set_reg(cfg_idx_e idx, logic [VAL_W-1:0] v);
      longint sv;
      sv = $signed(v);
      case (idx)
        CFG_LOOP_GAIN:  kc = sv;
        CFG_INT_GAIN:   ki = sv;
        CFG_DER_GAIN:   kd = sv;
        CFG_TIME_CONST: tau_ms = v[TAU_W-1:0];
        CFG_UPPER:      hi_lim = sv;
        CFG_LOWER:      lo_lim = sv;
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [VAL_W-1:0] sp, logic signed [VAL_W-1:0] meas,
                              logic [VAL_W-1:0] now);
      longint           s, m, dt, tau, err, p, d, o, t;
      logic [VAL_W-1:0] dt_raw;
      drive_item_t      r;
      s      = sp;
      m      = meas;
      dt_raw = now - prev_ms;
      dt     = dt_raw;
      tau    = (tau_ms == '0) ? 1 : tau_ms;
      err    = clip(s - m);
      r.status = CLAMP_NONE;
      r.zero   = 1'b0;

      p = scaled_mul(kc, err, FRAC_BITS);

      t = scaled_mul(ki, err, FRAC_BITS);
      t = scaled_mul(t, dt, 0);
      t = scaled_mul(t, kc, FRAC_BITS);
      integ = clip(integ + t / tau);

      // derivative on measurement, dropped when the interval is zero
      if (dt == 0) begin
        d      = 0;
        r.zero = 1'b1;
      end else begin
        t = scaled_mul(kd, kc, FRAC_BITS);
        t = scaled_mul(t, tau, 0);
        t = scaled_mul(t, clip(m - prev_meas), FRAC_BITS);
        d = clip(-(t / dt));
      end

      o = clip(p + integ + d);
      if (o > hi_lim || o < lo_lim) begin
        // upper test wins when the limits are crossed
        if (o > hi_lim) begin
          o        = hi_lim;
          r.status = CLAMP_UPPER;
        end else begin
          o        = lo_lim;
          r.status = CLAMP_LOWER;
        end
        t = scaled_mul(err, 2, 0);
        t = scaled_mul(t, dt, 0);
        t = scaled_mul(t, kc, FRAC_BITS);
        integ = clip(integ - t / tau);
      end

      prev_meas = m;
      prev_ms   = now;
      r.drive   = o[VAL_W-1:0];
      drive_due.push_back(r);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void check_drive(logic signed [VAL_W-1:0] drive, logic [1:0] status,
                              logic zero);
      drive_item_t e;
      if (drive_due.size() == 0) begin
        flag($sformatf("%0t: unexpected drive item %0d clamp %0d zero %0b",
                       $time, drive, status, zero));
        return;
      end
      e = drive_due.pop_front();
      if (drive !== e.drive || status !== e.status || zero !== e.zero) begin
        flag($sformatf("%0t: drive exp %0d got %0d, clamp exp %0d got %0d, zero exp %0b got %0b",
                       $time, e.drive, drive, e.status, status, e.zero, zero));
      end
    endfunction

    function bit all_good();
      if (drive_due.size() != 0) begin
        flag($sformatf("%0d drive items never arrived", drive_due.size()));
      end
      return failures == 0;
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [2:0]              cfg_idx_i;
  logic [VAL_W-1:0]        cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [VAL_W-1:0] setpoint_i;
  logic signed [VAL_W-1:0] measurement_i;
  logic [VAL_W-1:0]        now_ms_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [VAL_W-1:0] drive_o;
  logic [1:0]              clamp_status_o;
  logic                    zero_interval_o;

  drive_scoreboard  sb;
  logic [VAL_W-1:0] clock_ms;
  bit               hold_long;
  int               quiet_cycles;

  pid_controller_antiwindup dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .setpoint_i      (setpoint_i),
    .measurement_i   (measurement_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_o         (drive_o),
    .clamp_status_o  (clamp_status_o),
    .zero_interval_o (zero_interval_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_drive(drive_o, clamp_status_o, zero_interval_o);
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_sample(setpoint_i, measurement_i, now_ms_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("** pid_controller_antiwindup: FAILED **");
      $finish;
    end
  end

  // receiver: switches between no stall, random stall and stall bursts, with a long hold on request
  initial begin
    int style, style_left, run_left;
    bit stall_on;
    style      = 0;
    style_left = 0;
    run_left   = 0;
    stall_on   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_long = 1'b0;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 2);
        style_left = $urandom_range(100, 400);
      end
      style_left--;
      case (style)
        0: out_stall_i = 1'b0;
        1: out_stall_i = ($urandom_range(0, 2) == 0);
        default: begin
          if (run_left == 0) begin
            stall_on = !stall_on;
            run_left = $urandom_range(1, 12);
          end
          run_left--;
          out_stall_i = stall_on;
        end
      endcase
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [VAL_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic write_all(logic [VAL_W-1:0] kc, logic [VAL_W-1:0] ki,
                           logic [VAL_W-1:0] kd, logic [VAL_W-1:0] tau,
                           logic [VAL_W-1:0] hi, logic [VAL_W-1:0] lo);
    write_reg(CFG_LOOP_GAIN, kc);
    write_reg(CFG_INT_GAIN, ki);
    write_reg(CFG_DER_GAIN, kd);
    write_reg(CFG_TIME_CONST, tau);
    write_reg(CFG_UPPER, hi);
    write_reg(CFG_LOWER, lo);
  endtask

  // valid stays high across back-to-back items
  task automatic send_sample(logic [VAL_W-1:0] sp, logic [VAL_W-1:0] meas,
                             logic [VAL_W-1:0] now);
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    setpoint_i    = sp;
    measurement_i = meas;
    now_ms_i      = now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    clock_ms = now;
  endtask

  task automatic hold_sender(int n);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.drive_due.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = VMAX;
      1:       v = VMIN;
      2:       v = '0;
      3, 4:    v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h000A_0000);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [VAL_W-1:0] rand_gain();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = VMAX;
      1:       v = VMIN;
      2:       v = '0;
      3:       v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(0, 3) == 0) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [VAL_W-1:0] rand_limit();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = $urandom;
      1:       v = VMAX;
      2:       v = VMIN;
      default: begin
        v = $urandom_range(0, 32'h0064_0000);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [VAL_W-1:0] rand_step();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return $urandom;
      default: return $urandom_range(1, 100);
    endcase
  endfunction

  task automatic random_config();
    logic signed [VAL_W-1:0] a, b, hi, lo;
    logic [VAL_W-1:0]        tau;
    a = rand_limit();
    b = rand_limit();
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    case ($urandom_range(0, 5))
      0: begin
        hi = VMAX;
        lo = VMIN;
      end
      1: begin
        // crossed limits
        a  = hi;
        hi = lo;
        lo = a;
      end
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0:       tau = '0;
      1:       tau = 32'h0000_FFFF;
      2:       tau = 32'd1;
      3:       tau = $urandom;
      default: tau = $urandom_range(1, 2000);
    endcase
    write_all(rand_gain(), rand_gain(), rand_gain(), tau, hi, lo);
  endtask

  initial begin
    logic [VAL_W-1:0] sp, meas, target;
    bit               bursty;
    int               burst_left;

    sb            = new();
    hold_long     = 1'b0;
    quiet_cycles  = 0;
    clock_ms      = '0;
    burst_left    = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_LOOP_GAIN;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    setpoint_i    = '0;
    measurement_i = '0;
    now_ms_i      = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset configuration: first sample at time zero, error extremes, wrap
    send_sample('0, '0, '0);
    send_sample(VMAX, VMIN, 32'd1);
    send_sample(VMIN, VMAX, 32'hFFFF_FFFF);
    send_sample(32'h0001_0000, '0, 32'd4);
    send_sample(32'h0001_0000, 32'h0001_0000, 32'd4);
    drain();

    // narrow limits, zero time constant, derivative active
    write_all(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, '0,
              32'h0001_0000, 32'hFFFF_0000);
    send_sample(32'h0010_0000, '0, 32'd14);
    send_sample(32'hFFF0_0000, '0, 32'd24);
    send_sample(32'h0000_0100, 32'h0000_0080, 32'd25);
    send_sample('0, 32'h0000_8000, 32'd35);
    send_sample('0, 32'h0000_8000, 32'd35);
    drain();

    // crossed limits
    write_reg(CFG_UPPER, 32'hFFFF_0000);
    write_reg(CFG_LOWER, 32'h0001_0000);
    send_sample(32'h0100_0000, '0, 32'd40);
    send_sample(32'hFF00_0000, '0, 32'd41);
    send_sample('0, '0, 32'd41);
    drain();

    // extreme gains and the largest time constant
    write_all(VMIN, VMAX, VMIN, 32'h0000_FFFF, VMAX, VMIN);
    send_sample(VMAX, VMIN, 32'd1041);
    send_sample(VMIN, VMAX, 32'd1042);
    send_sample('0, VMIN, 32'd1043);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_config();
      bursty = (ph % 3 != 1);
      // long receiver hold while items keep coming back to back
      if (ph == 1) hold_long = 1'b1;
      target = rand_value();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (bursty) begin
          if (burst_left == 0) begin
            hold_sender($urandom_range(1, 15));
            burst_left = $urandom_range(1, 24);
          end
          burst_left--;
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            // loop near its setpoint
            sp   = target;
            meas = target + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
          end
          6: begin
            target = rand_value();
            sp     = target;
            meas   = rand_value();
          end
          default: begin
            sp   = rand_value();
            meas = rand_value();
          end
        endcase
        send_sample(sp, meas, clock_ms + rand_step());
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.all_good()) begin
      $display("** pid_controller_antiwindup: PASSED **");
    end else begin
      $display("** pid_controller_antiwindup: FAILED **");
    end
    $finish;
  end

endmodule
